// ===== rtl/core/mce_pkg.sv =====
package mce_pkg;

  // Field and register widths
  localparam int COORD_WIDTH_DEF = 32;
  localparam int CFG_DATA_W      = 32;
  localparam int MIN_W           = 32;
  localparam int DEN_W           = 31;
  localparam int QUANT_W         = 10;
  localparam int Q_W             = QUANT_W + 1;
  localparam int CODE_W          = 30;
  localparam int AXES            = 3;
  localparam int CFG_IDX_W       = 3;

  localparam logic [DEN_W-1:0]   EXT_RESET = DEN_W'(65536);
  localparam logic [QUANT_W-1:0] AXIS_MAX  = QUANT_W'(1023);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_X    = 3'd0,
    CFG_MIN_Y    = 3'd1,
    CFG_MIN_Z    = 3'd2,
    CFG_EXTENT_X = 3'd3,
    CFG_EXTENT_Y = 3'd4,
    CFG_EXTENT_Z = 3'd5
  } cfg_reg_t;

  localparam logic [31:0] SPREAD_M0 = 32'h0000_03ff;
  localparam logic [31:0] SPREAD_M1 = 32'h0e00_007f;
  localparam logic [31:0] SPREAD_M2 = 32'h0e07_000f;
  localparam logic [31:0] SPREAD_M3 = 32'h0e07_0381;
  localparam logic [31:0] SPREAD_M4 = 32'h0984_c261;
  localparam logic [31:0] SPREAD_M5 = 32'h0924_9249;

  // Move bit i of a 10-bit index to bit 3i.
  function automatic logic [31:0] spread3(input logic [QUANT_W-1:0] a);
    logic [31:0] b;
    b = 32'(a) & SPREAD_M0;
    b = (b | (b << 18)) & SPREAD_M1;
    b = (b | (b << 12)) & SPREAD_M2;
    b = (b | (b << 6))  & SPREAD_M3;
    b = (b | (b >> 2))  & SPREAD_M4;
    b = (b | (b >> 2))  & SPREAD_M5;
    return b;
  endfunction

endpackage

// ===== rtl/core/mce_front.sv =====
module mce_front #(
  parameter int COORD_WIDTH = mce_pkg::COORD_WIDTH_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  up_valid,
  output logic                                                  up_ready,
  input  logic [mce_pkg::AXES-1:0][COORD_WIDTH-1:0]             coord,
  input  logic [mce_pkg::AXES-1:0][mce_pkg::MIN_W-1:0]          lo,
  output logic                                                  dn_valid,
  input  logic                                                  dn_ready,
  output logic [mce_pkg::AXES-1:0][COORD_WIDTH+mce_pkg::QUANT_W-1:0] num
);

  localparam int NUM_W = COORD_WIDTH + mce_pkg::QUANT_W;

  logic [mce_pkg::AXES-1:0][COORD_WIDTH-1:0] lo_w;
  logic signed [COORD_WIDTH:0]               diff [mce_pkg::AXES];

  logic                                      s1_vld_r, s1_vld_nxt;
  logic [mce_pkg::AXES-1:0][COORD_WIDTH-1:0] mag_r, mag_nxt;
  logic                                      s1_ready;

  logic                                      s2_vld_r, s2_vld_nxt;
  logic [mce_pkg::AXES-1:0][NUM_W-1:0]       num_r, num_nxt;
  logic                                      s2_ready;

  assign s2_ready = !s2_vld_r || dn_ready;
  assign s1_ready = !s1_vld_r || s2_ready;
  assign up_ready = s1_ready;

  // Stage 1: offset from box minimum, clamp at zero
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    mag_nxt    = mag_r;
    for (int a = 0; a < mce_pkg::AXES; a++) begin
      // minima are 32 bits, zero-extended above that width
      lo_w[a] = COORD_WIDTH'(lo[a]);
      diff[a] = $signed({coord[a][COORD_WIDTH-1], coord[a]})
              - $signed({lo_w[a][COORD_WIDTH-1], lo_w[a]});
    end
    if (s1_ready) begin
      s1_vld_nxt = up_valid;
      for (int a = 0; a < mce_pkg::AXES; a++) begin
        mag_nxt[a] = (!diff[a][COORD_WIDTH] && (diff[a] != '0)) ?
                     diff[a][COORD_WIDTH-1:0] : '0;
      end
    end
  end

  // Stage 2: scale by 1023 as (d << 10) - d
  always_comb begin
    s2_vld_nxt = s2_vld_r;
    num_nxt    = num_r;
    if (s2_ready) begin
      s2_vld_nxt = s1_vld_r;
      for (int a = 0; a < mce_pkg::AXES; a++) begin
        num_nxt[a] = {mag_r[a], {mce_pkg::QUANT_W{1'b0}}}
                   - {{mce_pkg::QUANT_W{1'b0}}, mag_r[a]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    num_r <= num_nxt;
  end

  assign dn_valid = s2_vld_r;
  assign num      = num_r;

endmodule

// ===== rtl/core/mce_div_stage.sv =====
module mce_div_stage #(
  parameter int REM_W = 42,
  parameter int SHIFT = 0
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          up_valid,
  output logic                                          up_ready,
  input  logic [mce_pkg::AXES-1:0][REM_W-1:0]           rem_in,
  input  logic [mce_pkg::AXES-1:0][mce_pkg::Q_W-1:0]    q_in,
  input  logic [mce_pkg::AXES-1:0][mce_pkg::DEN_W-1:0]  den,
  output logic                                          dn_valid,
  input  logic                                          dn_ready,
  output logic [mce_pkg::AXES-1:0][REM_W-1:0]           rem_out,
  output logic [mce_pkg::AXES-1:0][mce_pkg::Q_W-1:0]    q_out
);

  logic                                          vld_r, vld_nxt;
  logic [mce_pkg::AXES-1:0][REM_W-1:0]           rem_r, rem_nxt;
  logic [mce_pkg::AXES-1:0][mce_pkg::Q_W-1:0]    q_r, q_nxt;
  logic [mce_pkg::AXES-1:0][REM_W-1:0]           d_sh;
  logic [mce_pkg::AXES-1:0]                      ge;

  assign up_ready = !vld_r || dn_ready;

  // One restoring step: subtract den << SHIFT when it fits, shift in quotient bit
  always_comb begin
    vld_nxt = vld_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    for (int a = 0; a < mce_pkg::AXES; a++) begin
      d_sh[a] = REM_W'(den[a]) << SHIFT;
      ge[a]   = rem_in[a] >= d_sh[a];
    end
    if (up_ready) begin
      vld_nxt = up_valid;
      for (int a = 0; a < mce_pkg::AXES; a++) begin
        rem_nxt[a] = ge[a] ? (rem_in[a] - d_sh[a]) : rem_in[a];
        q_nxt[a]   = {q_in[a][mce_pkg::Q_W-2:0], ge[a]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign dn_valid = vld_r;
  assign rem_out  = rem_r;
  assign q_out    = q_r;

endmodule

// ===== rtl/core/mce_back.sv =====
module mce_back (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        up_valid,
  output logic                                        up_ready,
  input  logic [mce_pkg::AXES-1:0][mce_pkg::Q_W-1:0]  q,
  output logic                                        dn_valid,
  input  logic                                        dn_ready,
  output logic [mce_pkg::CODE_W-1:0]                  code
);

  logic                                          vld_r, vld_nxt;
  logic [mce_pkg::CODE_W-1:0]                    code_r, code_nxt;
  logic [mce_pkg::AXES-1:0][mce_pkg::QUANT_W-1:0] idx;
  logic [31:0]                                   mix;

  assign up_ready = !vld_r || dn_ready;

  always_comb begin
    vld_nxt  = vld_r;
    code_nxt = code_r;
    // quotient bit 10 set means 1024 or more: saturate
    for (int a = 0; a < mce_pkg::AXES; a++) begin
      idx[a] = q[a][mce_pkg::Q_W-1] ? mce_pkg::AXIS_MAX : q[a][mce_pkg::QUANT_W-1:0];
    end
    mix = mce_pkg::spread3(idx[0])
        | (mce_pkg::spread3(idx[1]) << 1)
        | (mce_pkg::spread3(idx[2]) << 2);
    if (up_ready) begin
      vld_nxt  = up_valid;
      code_nxt = mix[mce_pkg::CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign dn_valid = vld_r;
  assign code     = code_r;

endmodule

// ===== rtl/core/mce_outbuf.sv =====
module mce_outbuf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [mce_pkg::CODE_W-1:0] up_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mce_pkg::CODE_W-1:0] out_data
);

  logic                       out_vld_r, out_vld_nxt;
  logic [mce_pkg::CODE_W-1:0] out_data_r, out_data_nxt;
  logic                       skid_vld_r, skid_vld_nxt;
  logic [mce_pkg::CODE_W-1:0] skid_data_r, skid_data_nxt;

  // ready comes from a register, so out_stall never reaches the pipeline directly
  assign up_ready = !skid_vld_r;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    skid_vld_nxt  = skid_vld_r;
    skid_data_nxt = skid_data_r;
    if (!out_vld_r || !out_stall) begin
      if (skid_vld_r) begin
        // drain the parked item first
        out_vld_nxt  = 1'b1;
        out_data_nxt = skid_data_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt  = up_valid;
        out_data_nxt = up_data;
      end
    end else if (up_valid && !skid_vld_r) begin
      // output held: park the arriving item
      skid_vld_nxt  = 1'b1;
      skid_data_nxt = up_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/morton_code_3d_encoder_top.sv =====
// 3D Morton encoder: each point is three signed fixed-point coordinates; every axis is
// quantized against the configured box as floor((coord - min) * 1023 / extent), clamped
// to 0..1023, and the three indices are interleaved into a 30-bit code (x in bit 0, y in
// bit 1, z in bit 2). One point is accepted per clock while in_stall is low. In order,
// the front stages form the offset and the scaling, a restoring divider works out one
// quotient bit per stage for all three axes in parallel, the back stage clamps and
// interleaves, and the output register holds the result. A second output entry lets
// the pipeline keep taking points while a result waits; in_stall rises only once every
// stage and both output entries hold items. An extent of zero acts as one.
// Write the box registers only while no point is in flight.
module morton_code_3d_encoder_top #(
  parameter int COORD_WIDTH = mce_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [COORD_WIDTH-1:0]               in_coord_x,
  input  logic [COORD_WIDTH-1:0]               in_coord_y,
  input  logic [COORD_WIDTH-1:0]               in_coord_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mce_pkg::CODE_W-1:0]           out_morton_code,
  input  logic                                 cfg_we,
  input  logic [mce_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [mce_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int NUM_W = COORD_WIDTH + mce_pkg::QUANT_W;
  localparam int DSH_W = mce_pkg::DEN_W + mce_pkg::QUANT_W;
  localparam int REM_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int STEPS = mce_pkg::Q_W;

  // Box registers
  logic [mce_pkg::AXES-1:0][mce_pkg::MIN_W-1:0] min_r, min_nxt;
  logic [mce_pkg::AXES-1:0][mce_pkg::DEN_W-1:0] ext_r, ext_nxt;
  logic [mce_pkg::AXES-1:0][mce_pkg::DEN_W-1:0] den;

  always_comb begin
    min_nxt = min_r;
    ext_nxt = ext_r;
    if (cfg_we) begin
      unique case (mce_pkg::cfg_reg_t'(cfg_idx))
        mce_pkg::CFG_MIN_X:    min_nxt[0] = cfg_wdata[mce_pkg::MIN_W-1:0];
        mce_pkg::CFG_MIN_Y:    min_nxt[1] = cfg_wdata[mce_pkg::MIN_W-1:0];
        mce_pkg::CFG_MIN_Z:    min_nxt[2] = cfg_wdata[mce_pkg::MIN_W-1:0];
        mce_pkg::CFG_EXTENT_X: ext_nxt[0] = cfg_wdata[mce_pkg::DEN_W-1:0];
        mce_pkg::CFG_EXTENT_Y: ext_nxt[1] = cfg_wdata[mce_pkg::DEN_W-1:0];
        mce_pkg::CFG_EXTENT_Z: ext_nxt[2] = cfg_wdata[mce_pkg::DEN_W-1:0];
        default: ;
      endcase
    end
    for (int a = 0; a < mce_pkg::AXES; a++) begin
      den[a] = (ext_r[a] == '0) ? mce_pkg::DEN_W'(1) : ext_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      ext_r <= {mce_pkg::AXES{mce_pkg::EXT_RESET}};
    end else begin
      min_r <= min_nxt;
      ext_r <= ext_nxt;
    end
  end

  // Front end: offset and scale
  logic                                       fr_ready;
  logic                                       fr_valid;
  logic [mce_pkg::AXES-1:0][COORD_WIDTH-1:0]  coord;
  logic [mce_pkg::AXES-1:0][NUM_W-1:0]        num;

  assign coord[0] = in_coord_x;
  assign coord[1] = in_coord_y;
  assign coord[2] = in_coord_z;
  assign in_stall = !fr_ready;

  // Divider chain
  logic [STEPS:0]                                         dv_valid;
  logic [STEPS:0]                                         dv_ready;
  logic [STEPS:0][mce_pkg::AXES-1:0][REM_W-1:0]           dv_rem;
  logic [STEPS:0][mce_pkg::AXES-1:0][mce_pkg::Q_W-1:0]    dv_q;

  mce_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (fr_ready),
    .coord    (coord),
    .lo       (min_r),
    .dn_valid (fr_valid),
    .dn_ready (dv_ready[0]),
    .num      (num)
  );

  assign dv_valid[0] = fr_valid;
  for (genvar a = 0; a < mce_pkg::AXES; a++) begin : g_seed
    assign dv_rem[0][a] = REM_W'(num[a]);
  end
  assign dv_q[0] = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_div
    mce_div_stage #(
      .REM_W (REM_W),
      .SHIFT (STEPS - 1 - k)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_valid[k]),
      .up_ready (dv_ready[k]),
      .rem_in   (dv_rem[k]),
      .q_in     (dv_q[k]),
      .den      (den),
      .dn_valid (dv_valid[k+1]),
      .dn_ready (dv_ready[k+1]),
      .rem_out  (dv_rem[k+1]),
      .q_out    (dv_q[k+1])
    );
  end

  // Clamp, interleave, output buffer
  logic                        bk_valid;
  logic                        ob_ready;
  logic [mce_pkg::CODE_W-1:0]  bk_code;

  mce_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dv_valid[STEPS]),
    .up_ready (dv_ready[STEPS]),
    .q        (dv_q[STEPS]),
    .dn_valid (bk_valid),
    .dn_ready (ob_ready),
    .code     (bk_code)
  );

  mce_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (bk_valid),
    .up_ready  (ob_ready),
    .up_data   (bk_code),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_morton_code)
  );

endmodule
